### rtl/imudr_pkg.sv
// Shared constants for the IMU dead-reckoning framer.
package imudr_pkg;

	localparam int unsigned FRAME_BYTES = 30;
	localparam logic [7:0] HDR_BYTE = 8'hAA;
	localparam logic [7:0] TRL_BYTE = 8'h55;

	localparam int unsigned US_W = 24;
	localparam int unsigned DT_W = 21;

	// dt = 1024 * (us / 15625) + (2048 * (us mod 15625) + 15625) / 31250.
	// Both divisions use a reciprocal rounded up, exact over their input ranges.
	localparam logic [24:0] DIV_D1 = 25'd15625;
	localparam logic [24:0] DIV_BIAS = 25'd15625;
	localparam logic [24:0] DIV_R1 = 25'd17592187;
	localparam logic [25:0] DIV_R2 = 26'd35184373;

	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_W = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_W = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RPT_W = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HDG_OFF = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LIM = 3'd4;

endpackage

### rtl/imudr_div.sv
// Constant divider that turns elapsed microseconds into unsigned Q5.16 seconds.
module imudr_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [imudr_pkg::US_W-1:0] elapsed_us,
	output logic                     done,
	output logic [imudr_pkg::DT_W-1:0] dt
);
	import imudr_pkg::*;

	logic            v_s1, v_s2, v_s3;
	logic            done_q;
	logic [US_W-1:0] us_s1, us_s2;
	logic [10:0]     h_s2, h_s3;
	logic [24:0]     m2_s3;
	logic [DT_W-1:0] dt_q;
	logic [48:0]     p1;
	logic [24:0]     hm;
	logic [24:0]     rem;
	logic [50:0]     p2;
	logic [DT_W-1:0] q2;

	assign p1 = 49'(us_s1) * 49'(DIV_R1);
	assign hm = 25'(h_s2) * DIV_D1;
	assign rem = 25'(us_s2) - hm;
	assign p2 = 51'(m2_s3) * 51'(DIV_R2);
	assign q2 = DT_W'(p2[50:40]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			done_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			us_s1 <= elapsed_us;
		end
		if (v_s1) begin
			h_s2 <= p1[48:38];
			us_s2 <= us_s1;
		end
		if (v_s2) begin
			h_s3 <= h_s2;
			m2_s3 <= {rem[13:0], 11'd0} + DIV_BIAS;
		end
		if (v_s3) begin
			dt_q <= {h_s3, 10'd0} + q2;
		end
	end

	assign done = done_q;
	assign dt = dt_q;

endmodule

### rtl/imu_dead_reckoning_framer_core.sv
// Top level of the IMU dead-reckoning framer: state memory, sequencer and frame output.
// An accepted sample first has its elapsed time turned into dt by the divider, then each motion
// axis and each angle in turn passes through the shared state memory and one multiplier.
// The 30 frame words then leave one per cycle while m_tready is high, and no new sample is
// accepted until the last frame word has been taken.
// Reset clears all filter state, the sequence count and the registers to their defaults.
module imu_dead_reckoning_framer_core #(
	parameter int unsigned AXES = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// accel_x, accel_y, accel_z, heading_deg, roll_deg, pitch_deg, elapsed_us
	input  logic [215:0]                  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// frame_byte
	output logic [7:0]                    m_tdata,
	output logic                          m_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [imudr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import imudr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV, ST_RD, ST_RDW, ST_MUL, ST_ACC, ST_WR, ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		OP_FA, OP_ADT, OP_VDT, OP_AHI, OP_ALO, OP_SP, OP_RP, OP_ANG
	} op_t;

	localparam logic [2:0] K_FA = 3'd0;
	localparam logic [2:0] K_VEL = 3'd1;
	localparam logic [2:0] K_POS = 3'd2;
	localparam logic [2:0] K_SPOS = 3'd3;
	localparam logic [2:0] K_RPOS = 3'd4;
	localparam logic [2:0] K_SANG = 3'd5;
	localparam int unsigned MEM_DEPTH = 24;

	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'h7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	state_t      state_q;
	op_t         op_q;
	logic        ang_ph_q;
	logic [1:0]  axis_q;
	logic [2:0]  kind_q;
	logic [4:0]  bc_q;
	logic [15:0] seq_q;

	logic [15:0] aw_q, pw_q, rw_q, lim_q;
	logic [31:0] off_q;

	logic [31:0] acc_q [3];
	logic [31:0] ang_q [3];
	logic [31:0] out_w_q [6];

	logic [31:0] fa_q, vel_q, pos_q, spos_q, rpos_q, sang_q;
	logic signed [37:0] adt_q, t1_q;
	logic signed [54:0] hi_q;
	logic signed [54:0] prod_s1;

	logic [31:0] mem_q [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] vld_q;
	logic [31:0] rdata_s1;
	logic        rvld_s1;
	logic        rd_s1;
	logic [2:0]  rkind_s1;
	logic [31:0] rval;

	logic [4:0]  addr;
	logic        re, we;
	logic [31:0] wdata;

	logic        accept;
	logic        div_done;
	logic [DT_W-1:0] dt;

	logic signed [32:0] mul_a;
	logic signed [21:0] mul_b;
	logic signed [54:0] pr;
	logic signed [38:0] rnd16;
	logic signed [63:0] tot, t2, np, nv;

	logic [15:0] seq_inc;
	logic signed [32:0] hd_d;
	logic [31:0] hd_sat;
	logic [4:0]  wb;
	logic [31:0] cur_w;

	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	imudr_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept),
		.elapsed_us (s_tdata[215:192]),
		.done       (div_done),
		.dt         (dt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aw_q <= 16'd328;
			pw_q <= 16'd1311;
			rw_q <= 16'd6554;
			off_q <= 32'd11796480;
			lim_q <= 16'd999;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ACCEL_W: aw_q <= cfg_data[15:0];
				CFG_POS_W:   pw_q <= cfg_data[15:0];
				CFG_RPT_W:   rw_q <= cfg_data[15:0];
				CFG_HDG_OFF: off_q <= cfg_data;
				CFG_SEQ_LIM: lim_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign seq_inc = seq_q + 16'd1;
	assign hd_d = $signed({s_tdata[127], s_tdata[127:96]}) - $signed({off_q[31], off_q});
	assign hd_sat = (hd_d[32] != hd_d[31]) ? (hd_d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
		: hd_d[31:0];

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q[0] <= s_tdata[31:0];
			acc_q[1] <= s_tdata[63:32];
			acc_q[2] <= s_tdata[95:64];
			ang_q[0] <= hd_sat;
			ang_q[1] <= s_tdata[159:128];
			ang_q[2] <= s_tdata[191:160];
		end
	end

	assign addr = {kind_q, axis_q};
	assign re = (state_q == ST_RD);
	assign we = (state_q == ST_WR);

	always_comb begin
		unique case (kind_q)
			K_FA:    wdata = fa_q;
			K_VEL:   wdata = vel_q;
			K_POS:   wdata = pos_q;
			K_SPOS:  wdata = spos_q;
			K_RPOS:  wdata = rpos_q;
			default: wdata = sang_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem_q[addr];
			rvld_s1 <= vld_q[addr];
			rkind_s1 <= kind_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= re;
			if (we) begin
				vld_q[addr] <= 1'b1;
			end
		end
	end

	assign rval = rvld_s1 ? rdata_s1 : 32'd0;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (op_q)
			OP_FA: begin
				mul_a = $signed({acc_q[axis_q][31], acc_q[axis_q]}) - $signed({fa_q[31], fa_q});
				mul_b = $signed({6'd0, aw_q});
			end
			OP_ADT: begin
				mul_a = $signed({fa_q[31], fa_q});
				mul_b = $signed({1'b0, dt});
			end
			OP_VDT: begin
				mul_a = $signed({vel_q[31], vel_q});
				mul_b = $signed({1'b0, dt});
			end
			OP_AHI: begin
				mul_a = $signed({{11{adt_q[37]}}, adt_q[37:16]});
				mul_b = $signed({1'b0, dt});
			end
			OP_ALO: begin
				mul_a = $signed({17'd0, adt_q[15:0]});
				mul_b = $signed({1'b0, dt});
			end
			OP_SP: begin
				mul_a = $signed({pos_q[31], pos_q}) - $signed({spos_q[31], spos_q});
				mul_b = $signed({6'd0, pw_q});
			end
			OP_RP: begin
				mul_a = $signed({spos_q[31], spos_q}) - $signed({rpos_q[31], rpos_q});
				mul_b = $signed({6'd0, rw_q});
			end
			OP_ANG: begin
				mul_a = $signed({ang_q[axis_q][31], ang_q[axis_q]})
					- $signed({sang_q[31], sang_q});
				mul_b = $signed({6'd0, rw_q});
			end
		endcase
	end

	assign pr = prod_s1 + 55'sd32768;
	assign rnd16 = pr[54:16];
	assign tot = (64'(hi_q) <<< 16) + 64'(prod_s1) + 64'sd65536;
	assign t2 = tot >>> 17;
	assign np = 64'($signed(pos_q)) + 64'(t1_q) + t2;
	assign nv = 64'($signed(vel_q)) + 64'(adt_q);

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_s1 <= mul_a * mul_b;
		end
		if (rd_s1) begin
			unique case (rkind_s1)
				K_FA:    fa_q <= rval;
				K_VEL:   vel_q <= rval;
				K_POS:   pos_q <= rval;
				K_SPOS:  spos_q <= rval;
				K_RPOS:  rpos_q <= rval;
				default: sang_q <= rval;
			endcase
		end else if (state_q == ST_ACC) begin
			unique case (op_q)
				OP_FA:  fa_q <= fa_q + rnd16[31:0];
				OP_ADT: adt_q <= rnd16[37:0];
				OP_VDT: t1_q <= rnd16[37:0];
				OP_AHI: hi_q <= prod_s1;
				OP_ALO: begin
					pos_q <= sat32(np);
					vel_q <= sat32(nv);
				end
				OP_SP:  spos_q <= spos_q + rnd16[31:0];
				OP_RP:  rpos_q <= rpos_q + rnd16[31:0];
				OP_ANG: sang_q <= sang_q + rnd16[31:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_FA;
			ang_ph_q <= 1'b0;
			axis_q <= '0;
			kind_q <= K_FA;
			bc_q <= '0;
			seq_q <= '0;
			for (int i = 0; i < 6; i++) begin
				out_w_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						seq_q <= (seq_inc > lim_q) ? 16'd0 : seq_inc;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						ang_ph_q <= 1'b0;
						axis_q <= '0;
						kind_q <= K_FA;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					if (ang_ph_q || kind_q == K_RPOS) begin
						state_q <= ST_RDW;
					end else begin
						kind_q <= kind_q + 3'd1;
					end
				end
				ST_RDW: begin
					op_q <= ang_ph_q ? OP_ANG : OP_FA;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					state_q <= ST_MUL;
					unique case (op_q)
						OP_FA:  op_q <= OP_ADT;
						OP_ADT: op_q <= OP_VDT;
						OP_VDT: op_q <= OP_AHI;
						OP_AHI: op_q <= OP_ALO;
						OP_ALO: op_q <= OP_SP;
						OP_SP:  op_q <= OP_RP;
						OP_RP, OP_ANG: begin
							kind_q <= ang_ph_q ? K_SANG : K_FA;
							state_q <= ST_WR;
						end
					endcase
				end
				ST_WR: begin
					if (kind_q == K_RPOS) begin
						out_w_q[3'(axis_q) + 3'd3] <= rpos_q;
					end
					if (kind_q == K_SANG) begin
						out_w_q[3'(axis_q)] <= sang_q;
					end
					if (ang_ph_q) begin
						if (axis_q == 2'd2) begin
							bc_q <= '0;
							state_q <= ST_EMIT;
						end else begin
							axis_q <= axis_q + 2'd1;
							state_q <= ST_RD;
						end
					end else if (kind_q == K_RPOS) begin
						if (axis_q == 2'(AXES - 1)) begin
							ang_ph_q <= 1'b1;
							axis_q <= '0;
							kind_q <= K_SANG;
						end else begin
							axis_q <= axis_q + 2'd1;
							kind_q <= K_FA;
						end
						state_q <= ST_RD;
					end else begin
						kind_q <= kind_q + 3'd1;
					end
				end
				ST_EMIT: begin
					if (m_tready) begin
						if (bc_q == 5'(FRAME_BYTES - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							bc_q <= bc_q + 5'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign wb = bc_q - 5'd4;
	assign cur_w = out_w_q[wb[4:2]];

	always_comb begin
		priority if (bc_q < 5'd2) begin
			m_tdata = HDR_BYTE;
		end else if (bc_q == 5'd2) begin
			m_tdata = seq_q[7:0];
		end else if (bc_q == 5'd3) begin
			m_tdata = seq_q[15:8];
		end else if (bc_q >= 5'd28) begin
			m_tdata = TRL_BYTE;
		end else begin
			unique case (wb[1:0])
				2'd0: m_tdata = cur_w[7:0];
				2'd1: m_tdata = cur_w[15:8];
				2'd2: m_tdata = cur_w[23:16];
				default: m_tdata = cur_w[31:24];
			endcase
		end
	end

	assign m_tvalid = (state_q == ST_EMIT);
	assign m_tlast = (bc_q == 5'(FRAME_BYTES - 1));

endmodule

### rtl/imudr_chk.sv
// Port-level checks for the IMU dead-reckoning framer and their binding.
module imudr_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);
	import imudr_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output word changed");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> !m_tvalid)
		else $error("sample taken while a frame is being sent");

	a_trailer: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata == TRL_BYTE)
		else $error("last word of frame is not the trailer");

	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid)
		else $error("frame followed by another without a new sample");

endmodule

bind imu_dead_reckoning_framer_core imudr_chk u_imudr_chk (.*);
